// ----- src/cic_pkg.sv -----
// ============================================================================
// cic_pkg - shared types and constants for the interpolated clock block
// Beat payloads, controller/datapath command and status groups, constants.
// ============================================================================
`default_nettype none

package cic_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRECISION      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INSTAB_PCT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SHIFT  = 3'd5;

    localparam logic [62:0] MASK63          = {63{1'b1}};
    localparam logic [63:0] TICKS_PER_SEC   = 64'd10000000;
    localparam logic [62:0] ANOMALY_TICKS   = 63'd100000000;
    // largest counter distance whose product with ticks/s stays below 2^63
    localparam logic [62:0] FREQ_CNT_LIMIT  = 63'd922337203685;

    localparam logic [62:0] RST_MAX_PERIOD  = 63'd1280000000;
    localparam logic [62:0] RST_PRECISION   = 63'd500000;
    localparam logic [6:0]  RST_INSTAB_PCT  = 7'd10;
    localparam logic [62:0] RST_INIT_PERIOD = 63'd10000000;
    localparam logic [5:0]  MAX_SHIFT       = 6'd32;

    typedef struct packed {
        logic [62:0] sys_time;
        logic [62:0] counter_value;
    } in_t;

    typedef struct packed {
        logic [62:0] time_value;
        logic        recalibrated;
        logic        unstable;
        logic        clamped;
    } out_t;

    typedef enum logic [1:0] {
        MS_EST = 2'd0,
        MS_FRQ = 2'd1,
        MS_STB = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     lat_in;
        logic     calc;
        logic     first;
        mul_sel_t mul_sel;
        logic     mul_hi;
        logic     mul_en;
        logic     acc_load;
        logic     acc_add;
        logic     est_sat;
        logic     est_add;
        logic     take_est;
        logic     take_st;
        logic     set_recal;
        logic     clr_minmax;
        logic     div1_start;
        logic     div2_start;
        logic     freq_lat;
        logic     scale_lat;
        logic     stb_prep;
        logic     stb_cmp;
        logic     period_upd;
        logic     rebase;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic base_valid;
        logic accept_est;
        logic period_zero;
        logic freq_ok;
        logic expired;
        logic div_busy;
        logic freq_zero;
        logic m_valid;
    } sts_t;

    function automatic logic [5:0] cap_shift(input logic [5:0] s);
        return (s > MAX_SHIFT) ? MAX_SHIFT : s;
    endfunction

    // 100 / pct, with zero treated as one and anything above 100 giving zero
    function automatic logic [6:0] pct_ratio(input logic [6:0] p);
        logic [6:0] k;
        priority if (p <= 7'd1)  k = 7'd100;
        else if (p == 7'd2)      k = 7'd50;
        else if (p == 7'd3)      k = 7'd33;
        else if (p == 7'd4)      k = 7'd25;
        else if (p == 7'd5)      k = 7'd20;
        else if (p == 7'd6)      k = 7'd16;
        else if (p == 7'd7)      k = 7'd14;
        else if (p == 7'd8)      k = 7'd12;
        else if (p == 7'd9)      k = 7'd11;
        else if (p == 7'd10)     k = 7'd10;
        else if (p == 7'd11)     k = 7'd9;
        else if (p == 7'd12)     k = 7'd8;
        else if (p <= 7'd14)     k = 7'd7;
        else if (p <= 7'd16)     k = 7'd6;
        else if (p <= 7'd20)     k = 7'd5;
        else if (p <= 7'd25)     k = 7'd4;
        else if (p <= 7'd33)     k = 7'd3;
        else if (p <= 7'd50)     k = 7'd2;
        else if (p <= 7'd100)    k = 7'd1;
        else                     k = 7'd0;
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- src/cic_div.sv -----
// ============================================================================
// cic_div - iterative 64-bit unsigned divider
// Restoring radix-2, one quotient bit per cycle; also reports quotient bit length.
// ============================================================================
`default_nettype none

module cic_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             busy,
    output logic [63:0]      quotient,
    output logic [6:0]       bit_len
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg;
    logic [6:0]  step_reg, step_next;
    logic [6:0]  bl_reg, bl_next;
    logic        busy_reg, busy_next;
    logic [64:0] rem_sh;
    logic        ge;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[63]};
        ge        = (rem_sh >= {1'b0, den_reg});
        rem_next  = ge ? 64'(rem_sh - {1'b0, den_reg}) : rem_sh[63:0];
        quo_next  = {quo_reg[62:0], ge};
        step_next = step_reg - 7'd1;
        // first set quotient bit fixes the bit length
        bl_next   = (ge && bl_reg == 7'd0) ? step_reg : bl_reg;
        busy_next = (step_reg != 7'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 7'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= 7'd64;
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
            bl_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            bl_reg  <= bl_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign bit_len  = bl_reg;

endmodule

`default_nettype wire

// ----- src/cic_dp.sv -----
// ============================================================================
// cic_dp - datapath of the interpolated clock
// Holds configuration and calibration state, the shared multiplier and divider.
// ============================================================================
`default_nettype none

module cic_dp
    import cic_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire in_t                  s_data,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data
);

    logic [62:0] max_period_reg, precision_reg, mask_reg;
    logic [6:0]  pct_reg;

    logic        base_valid_reg;
    logic [62:0] sys_base_reg, count_base_reg;
    logic [31:0] scale_mul_reg;
    logic [5:0]  scale_shift_reg;
    logic [62:0] recal_period_reg;
    logic [63:0] min_freq_reg, max_freq_reg;
    logic [62:0] last_time_reg, last_time_next;

    logic [62:0] st_reg, tsc_reg, cnt_reg, dist_reg;
    logic        st_pos_reg;
    logic [63:0] mp_reg;
    logic [95:0] acc_reg;
    logic [62:0] sc_reg, est_reg, cand_reg;
    logic        expired_reg;
    logic [63:0] freq_reg, diff_reg;
    logic [5:0]  sh_reg;
    logic [6:0]  k_reg;
    logic        recal_reg, unstable_reg;
    out_t        out_reg, out_next;
    logic        m_valid_reg;

    logic [31:0] mul_a, mul_b;
    logic [95:0] shifted;
    logic [63:0] sum64, dbl;
    logic [62:0] absd;
    logic        div_busy;
    logic [63:0] div_q, div_dividend, div_divisor;
    logic [6:0]  div_bl;

    cic_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div1_start | cmd.div2_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q),
        .bit_len  (div_bl)
    );

    assign div_dividend = cmd.div2_start ? (TICKS_PER_SEC << sh_reg) : acc_reg[63:0];
    assign div_divisor  = cmd.div2_start ? freq_reg : {1'b0, dist_reg};

    always_comb begin
        unique case (cmd.mul_sel)
            MS_EST: begin
                mul_a = cmd.mul_hi ? {1'b0, cnt_reg[62:32]} : cnt_reg[31:0];
                mul_b = scale_mul_reg;
            end
            MS_FRQ: begin
                mul_a = cmd.mul_hi ? {1'b0, cnt_reg[62:32]} : cnt_reg[31:0];
                mul_b = TICKS_PER_SEC[31:0];
            end
            MS_STB: begin
                mul_a = cmd.mul_hi ? diff_reg[63:32] : diff_reg[31:0];
                mul_b = {25'd0, k_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        shifted = acc_reg >> scale_shift_reg;
        sum64   = {1'b0, sys_base_reg} + {1'b0, sc_reg};
        dbl     = {recal_period_reg, 1'b0};
        absd    = (st_reg >= est_reg) ? (st_reg - est_reg) : (est_reg - st_reg);
    end

    // monotonic output stage
    always_comb begin
        out_next.recalibrated = recal_reg;
        out_next.unstable     = unstable_reg;
        if (cand_reg < last_time_reg && (last_time_reg - cand_reg) <= ANOMALY_TICKS) begin
            out_next.time_value = (last_time_reg != MASK63) ? last_time_reg + 63'd1 : MASK63;
            out_next.clamped    = 1'b1;
        end else begin
            out_next.time_value = cand_reg;
            out_next.clamped    = 1'b0;
        end
        last_time_next = out_next.time_value;
    end

    always_comb begin
        sts.base_valid  = base_valid_reg;
        sts.accept_est  = !expired_reg && (absd < precision_reg);
        sts.period_zero = (recal_period_reg == '0);
        sts.freq_ok     = st_pos_reg && (cnt_reg != '0) && (cnt_reg <= FREQ_CNT_LIMIT);
        sts.expired     = expired_reg;
        sts.div_busy    = div_busy;
        sts.freq_zero   = (div_q == '0);
        sts.m_valid     = m_valid_reg;
    end

    // control and calibration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_period_reg   <= RST_MAX_PERIOD;
            precision_reg    <= RST_PRECISION;
            pct_reg          <= RST_INSTAB_PCT;
            mask_reg         <= MASK63;
            base_valid_reg   <= 1'b0;
            sys_base_reg     <= '0;
            count_base_reg   <= '0;
            scale_mul_reg    <= '0;
            scale_shift_reg  <= MAX_SHIFT;
            recal_period_reg <= RST_INIT_PERIOD;
            min_freq_reg     <= '1;
            max_freq_reg     <= '0;
            last_time_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MAX_PERIOD:     max_period_reg   <= cfg_data[62:0];
                    REG_PRECISION:      precision_reg    <= cfg_data[62:0];
                    REG_INSTAB_PCT:     pct_reg          <= cfg_data[6:0];
                    REG_COUNTER_MASK:   mask_reg         <= cfg_data[62:0];
                    REG_INITIAL_PERIOD: recal_period_reg <= cfg_data[62:0];
                    REG_INITIAL_SHIFT:  scale_shift_reg  <= cap_shift(cfg_data[5:0]);
                    default: ;
                endcase
            end
            if (cmd.first || cmd.rebase) begin
                base_valid_reg <= 1'b1;
                sys_base_reg   <= st_reg;
                count_base_reg <= tsc_reg;
            end
            if (cmd.clr_minmax) begin
                min_freq_reg <= '1;
                max_freq_reg <= '0;
            end
            if (cmd.scale_lat) begin
                scale_mul_reg   <= div_q[31:0];
                scale_shift_reg <= sh_reg;
                if (freq_reg < min_freq_reg) min_freq_reg <= freq_reg;
                if (freq_reg > max_freq_reg) max_freq_reg <= freq_reg;
            end
            if (cmd.period_upd) begin
                recal_period_reg <= (dbl < {1'b0, max_period_reg}) ? dbl[62:0] : max_period_reg;
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cmd.out_load) begin
                m_valid_reg   <= 1'b1;
                last_time_reg <= last_time_next;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.lat_in) begin
            st_reg       <= s_data.sys_time;
            tsc_reg      <= s_data.counter_value;
            recal_reg    <= 1'b0;
            unstable_reg <= 1'b0;
        end
        if (cmd.calc) begin
            cnt_reg    <= (tsc_reg - count_base_reg) & mask_reg;
            dist_reg   <= (st_reg >= sys_base_reg) ? (st_reg - sys_base_reg)
                                                   : (sys_base_reg - st_reg);
            st_pos_reg <= (st_reg > sys_base_reg);
        end
        if (cmd.mul_en) mp_reg <= mul_a * mul_b;
        if (cmd.acc_load) acc_reg <= {32'd0, mp_reg};
        if (cmd.acc_add) acc_reg <= acc_reg + {mp_reg, 32'd0};
        if (cmd.est_sat) begin
            sc_reg      <= (shifted[95:63] != '0) ? MASK63 : shifted[62:0];
            expired_reg <= (dist_reg > recal_period_reg);
        end
        if (cmd.est_add) est_reg <= sum64[63] ? MASK63 : sum64[62:0];
        if (cmd.take_est) cand_reg <= est_reg;
        if (cmd.take_st || cmd.first) cand_reg <= st_reg;
        if (cmd.set_recal) recal_reg <= 1'b1;
        if (cmd.freq_lat) begin
            freq_reg <= div_q;
            sh_reg   <= ({1'b0, scale_shift_reg} < div_bl) ? scale_shift_reg : div_bl[5:0];
        end
        if (cmd.stb_prep) begin
            diff_reg <= max_freq_reg - min_freq_reg;
            k_reg    <= pct_ratio(pct_reg);
        end
        if (cmd.stb_cmp) unstable_reg <= (k_reg != '0) && (acc_reg > {32'd0, max_freq_reg});
        if (cmd.out_load) out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- src/cic_ctrl.sv -----
// ============================================================================
// cic_ctrl - sequencer of the interpolated clock
// One-hot state machine that steps the datapath through estimate and recalibration.
// ============================================================================
`default_nettype none

module cic_ctrl
    import cic_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_CALC   = 18'h00002,
        S_MUL0   = 18'h00004,
        S_MUL1   = 18'h00008,
        S_MUL2   = 18'h00010,
        S_EST0   = 18'h00020,
        S_EST1   = 18'h00040,
        S_DECIDE = 18'h00080,
        S_DIV1S  = 18'h00100,
        S_DIV1W  = 18'h00200,
        S_FREQ   = 18'h00400,
        S_DIV2S  = 18'h00800,
        S_DIV2W  = 18'h01000,
        S_SCALE  = 18'h02000,
        S_PREP   = 18'h04000,
        S_STB    = 18'h08000,
        S_REBASE = 18'h10000,
        S_OUT    = 18'h20000
    } state_t;

    state_t   state_reg, state_next;
    mul_sel_t job_reg, job_next;

    always_comb begin
        state_next  = state_reg;
        job_next    = job_reg;
        cmd         = '0;
        cmd.mul_sel = job_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.lat_in = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (!sts.base_valid) begin
                    cmd.first  = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.calc   = 1'b1;
                    job_next   = MS_EST;
                    state_next = S_MUL0;
                end
            end
            S_MUL0: begin
                cmd.mul_en = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                cmd.acc_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_hi   = 1'b1;
                state_next   = S_MUL2;
            end
            S_MUL2: begin
                cmd.acc_add = 1'b1;
                unique case (job_reg)
                    MS_EST:  state_next = S_EST0;
                    MS_FRQ:  state_next = S_DIV1S;
                    MS_STB:  state_next = S_STB;
                    default: state_next = S_IDLE;
                endcase
            end
            S_EST0: begin
                cmd.est_sat = 1'b1;
                state_next  = S_EST1;
            end
            S_EST1: begin
                cmd.est_add = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (sts.accept_est) begin
                    cmd.take_est = 1'b1;
                    state_next   = S_OUT;
                end else if (sts.period_zero) begin
                    cmd.take_st = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    cmd.take_st    = 1'b1;
                    cmd.set_recal  = 1'b1;
                    cmd.clr_minmax = sts.expired;
                    if (sts.freq_ok) begin
                        job_next   = MS_FRQ;
                        state_next = S_MUL0;
                    end else begin
                        state_next = S_REBASE;
                    end
                end
            end
            S_DIV1S: begin
                cmd.div1_start = 1'b1;
                state_next     = S_DIV1W;
            end
            S_DIV1W: begin
                if (!sts.div_busy) state_next = S_FREQ;
            end
            S_FREQ: begin
                cmd.freq_lat = 1'b1;
                state_next   = sts.freq_zero ? S_REBASE : S_DIV2S;
            end
            S_DIV2S: begin
                cmd.div2_start = 1'b1;
                state_next     = S_DIV2W;
            end
            S_DIV2W: begin
                if (!sts.div_busy) state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale_lat = 1'b1;
                state_next    = S_PREP;
            end
            S_PREP: begin
                cmd.stb_prep = 1'b1;
                job_next     = MS_STB;
                state_next   = S_MUL0;
            end
            S_STB: begin
                cmd.stb_cmp    = 1'b1;
                cmd.period_upd = sts.expired;
                state_next     = S_REBASE;
            end
            S_REBASE: begin
                cmd.rebase = sts.expired;
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!sts.m_valid || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            job_reg   <= MS_EST;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// ----- src/counter_interpolated_clock.sv -----
// ============================================================================
// counter_interpolated_clock - counter interpolated time source
// Turns (system time, counter) beats into corrected monotonic time beats.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one (sys_time, counter_value) beat; each
//   produces exactly one m_data beat on m_valid/m_ready. cfg_valid/cfg_data
//   with cfg_index write registers 0..5; cfg_ready is always high, and
//   writes are expected only while no item is in flight.
//   The first beat after reset goes from CALC straight to OUT before m_valid
//   rises; an accepted estimate passes CALC, MUL0, MUL1, MUL2, EST0, EST1,
//   DECIDE and OUT. A recalibration adds up to two divisions on the shared
//   divider plus the multiply steps. One item is processed at a time;
//   s_ready is high only while the sequencer is idle.
//   The result sits in an output register, so the sequencer returns to idle
//   and takes the next beat while the result waits; a following result
//   holds until the receiver takes the previous one.
//   Reset (aresetn low, synchronous) loads default registers, clears the
//   base pair and drops m_valid.
// ============================================================================
`default_nettype none

module counter_interpolated_clock
    import cic_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    cic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cic_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- src/cic_checker.sv -----
// ============================================================================
// cic_checker - port level checks for the interpolated clock
// Watches the top level ports; attached by bind.
// ============================================================================
`default_nettype none

module cic_checker
    import cic_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while item in flight");

    a_unstable_recal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.unstable |-> m_data.recalibrated)
        else $error("unstable flagged without recalibration");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear output and idle");

endmodule

bind counter_interpolated_clock cic_checker u_cic_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- verif/tb_counter_interpolated_clock.sv -----
// ============================================================================
// tb_counter_interpolated_clock - self-checking bench for the interpolated clock
// Drives (system time, counter) beats through valid/ready with random idling,
// predicts each time beat with an in-bench model of the extrapolation and
// recalibration, and compares every result field in order.
// ============================================================================
`default_nettype none

module tb_counter_interpolated_clock;
    import cic_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEG_ITEMS      = 84;
    localparam int N_PHASES       = 6;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    counter_interpolated_clock dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        bit   fixed;
        out_t value;
    } typed_t;

    typedef struct {
        in_t  beat;
        bit   fixed;
        out_t value;
    } row_t;

    // predictor copy of registers and state
    logic [63:0] pm_max_period, pm_precision, pm_mask, pm_init_period;
    logic [6:0]  pm_pct;
    logic [5:0]  pm_init_shift;
    logic        pm_base_ok;
    logic [63:0] pm_sys_base, pm_cnt_base, pm_period, pm_min_f, pm_max_f, pm_last;
    logic [31:0] pm_mul;
    logic [5:0]  pm_shift;

    out_t   time_q[$];
    typed_t typed_q[$];
    int     errors;
    int     tx_idle_pct, rx_idle_pct;
    int     hold_tok, hold_seen, hold_cnt;
    int     quiet;
    logic [63:0] seq_st, seq_cnt, seq_ratio;

    localparam logic [63:0] M63 = {1'b0, MASK63};

    function automatic logic [63:0] absdiff(logic [63:0] a, logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [5:0] clip_shift(logic [5:0] s);
        return (s > 6'd32) ? 6'd32 : s;
    endfunction

    task automatic load_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
        case (idx)
            REG_MAX_PERIOD:     pm_max_period = v & M63;
            REG_PRECISION:      pm_precision  = v & M63;
            REG_INSTAB_PCT:     pm_pct        = v[6:0];
            REG_COUNTER_MASK:   pm_mask       = v & M63;
            REG_INITIAL_PERIOD: begin
                pm_init_period = v & M63;
                pm_period      = pm_init_period;
            end
            REG_INITIAL_SHIFT:  begin
                pm_init_shift = v[5:0];
                pm_shift      = clip_shift(pm_init_shift);
            end
            default: ;
        endcase
    endtask

    task automatic reset_model();
        pm_max_period  = 64'd1280000000;
        pm_precision   = 64'd500000;
        pm_pct         = 7'd10;
        pm_mask        = M63;
        pm_init_period = 64'd10000000;
        pm_init_shift  = 6'd32;
        pm_base_ok     = 1'b0;
        pm_sys_base    = '0;
        pm_cnt_base    = '0;
        pm_mul         = '0;
        pm_shift       = 6'd32;
        pm_period      = pm_init_period;
        pm_min_f       = '1;
        pm_max_f       = '0;
        pm_last        = '0;
    endtask

    function automatic out_t predict_time(in_t d);
        logic [63:0] st, tsc, r, cnt, sdist, scaled, ct, freq, k, dbl;
        logic [95:0] prod;
        logic [5:0]  sh;
        int          bl;
        logic        expired, rc, un, cl;
        out_t        o;
        st = {1'b0, d.sys_time};
        tsc = {1'b0, d.counter_value};
        r = st;
        rc = 0; un = 0; cl = 0;
        if (!pm_base_ok) begin
            pm_sys_base = st;
            pm_cnt_base = tsc;
            pm_base_ok  = 1'b1;
        end else begin
            cnt   = (tsc - pm_cnt_base) & pm_mask;
            sdist = absdiff(st, pm_sys_base);
            prod  = ({32'b0, cnt} * {64'b0, pm_mul}) >> pm_shift;
            scaled = (prod > {32'b0, M63}) ? M63 : prod[63:0];
            ct = pm_sys_base + scaled;
            if (ct > M63) ct = M63;
            expired = sdist > pm_period;
            if (!expired && absdiff(st, ct) < pm_precision) begin
                r = ct;
            end else if (pm_period != 0) begin
                rc = 1;
                if (expired) begin
                    pm_min_f = '1;
                    pm_max_f = '0;
                end
                if (st > pm_sys_base && cnt > 0 && cnt <= {1'b0, FREQ_CNT_LIMIT}) begin
                    freq = cnt * TICKS_PER_SEC / sdist;
                    if (freq != 0) begin
                        bl = 0;
                        for (int i = 0; i < 64; i++) if (freq[i]) bl = i + 1;
                        sh = (pm_shift < bl) ? pm_shift : 6'(bl);
                        pm_shift = sh;
                        pm_mul = 32'((TICKS_PER_SEC << sh) / freq);
                        if (freq < pm_min_f) pm_min_f = freq;
                        if (freq > pm_max_f) pm_max_f = freq;
                        k = 64'd100 / ((pm_pct == 0) ? 64'd1 : 64'(pm_pct));
                        if (k != 0 && pm_max_f - pm_min_f > pm_max_f / k) un = 1;
                        if (expired) begin
                            dbl = pm_period * 2;
                            pm_period = (dbl < pm_max_period) ? dbl : pm_max_period;
                        end
                    end
                end
                if (expired) begin
                    pm_sys_base = st;
                    pm_cnt_base = tsc;
                end
            end
        end
        if (r < pm_last) begin
            if (pm_last - r > {1'b0, ANOMALY_TICKS}) begin
                pm_last = r;
            end else begin
                r = (pm_last < M63) ? pm_last + 1 : M63;
                pm_last = r;
                cl = 1;
            end
        end else begin
            pm_last = r;
        end
        o.time_value   = r[62:0];
        o.recalibrated = rc;
        o.unstable     = un;
        o.clamped      = cl;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // monitor: predicts on accepted inputs and checks accepted results
    always @(posedge aclk) begin
        out_t   want;
        typed_t t;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) load_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                want = predict_time(s_data);
                t = typed_q.pop_front();
                time_q.push_back(t.fixed ? t.value : want);
            end
            if (m_valid && m_ready) begin
                if (time_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_data.time_value, 64'd0);
                end else begin
                    want = time_q.pop_front();
                    if (m_data.time_value !== want.time_value)
                        report_mismatch("time_value", m_data.time_value, want.time_value);
                    if (m_data.recalibrated !== want.recalibrated)
                        report_mismatch("recalibrated", m_data.recalibrated, want.recalibrated);
                    if (m_data.unstable !== want.unstable)
                        report_mismatch("unstable", m_data.unstable, want.unstable);
                    if (m_data.clamped !== want.clamped)
                        report_mismatch("clamped", m_data.clamped, want.clamped);
                end
            end
        end
    end

    // receiver with random stalls and a long hold-off on request
    always @(posedge aclk) begin
        if (hold_tok != hold_seen) begin
            hold_seen <= hold_tok;
            hold_cnt  <= 400;
            m_ready   <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_beat(in_t d, bit fixed, out_t value);
        typed_t t;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        t.fixed = fixed;
        t.value = value;
        typed_q.push_back(t);
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        // let the monitor take in the last accepted beat first
        @(posedge aclk);
        while (time_q.size() != 0) @(posedge aclk);
    endtask

    function automatic in_t next_beat();
        in_t         d;
        logic [63:0] step;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 78) begin
            // well-formed: counter advances with time at the current ratio
            if ($urandom_range(9) == 0) step = $urandom_range(1, 30000000);
            else step = $urandom_range(1, 400000);
            seq_st  = seq_st + step;
            seq_cnt = seq_cnt + step * seq_ratio + $urandom_range(0, 3 * seq_ratio);
            if ($urandom_range(19) == 0) seq_ratio = $urandom_range(1, 3000);
        end else if (pick < 88) begin
            // step back in time, small or far
            if ($urandom_range(1)) seq_st = seq_st - $urandom_range(1, 2000000);
            else seq_st = seq_st - $urandom_range(100000000, 400000000);
        end else begin
            seq_st  = {$urandom, $urandom};
            seq_cnt = {$urandom, $urandom};
        end
        seq_st  = seq_st & M63;
        seq_cnt = seq_cnt & M63;
        d.sys_time      = seq_st[62:0];
        d.counter_value = seq_cnt[62:0];
        return d;
    endfunction

    row_t rows[$];
    logic [63:0] cfg_set [N_PHASES][6];

    initial begin
        out_t none;
        row_t rw;
        none = '0;
        errors = 0;
        hold_tok = 0; hold_seen = 0; hold_cnt = 0;
        quiet = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_PERIOD;
        cfg_data = '0;
        reset_model();
        seq_st = 64'd5000000;
        seq_cnt = 64'd123456;
        seq_ratio = 64'd100;

        cfg_set[0] = '{64'd1280000000, 64'd500000, 64'd10, M63, 64'd10000000, 64'd32};
        cfg_set[1] = '{64'd1, 64'd1, 64'd0, 64'hFFFF_FFFF, 64'd0, 64'd0};
        cfg_set[2] = '{M63, M63, 64'd127, M63, M63, 64'd63};
        cfg_set[3] = '{64'd2000000, 64'd200000, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF,
                       64'd1000, 64'd20};
        cfg_set[4] = '{64'd40000000, 64'd1000, 64'd100, 64'hFF_FFFF, 64'd5000000, 64'd16};
        cfg_set[5] = '{64'h8000_0000_4C4B_4000, 64'd300000, 64'd50, M63,
                       64'd8000000, 64'd40};

        // first beat sets the base and passes sys_time straight through
        rows.push_back('{'{63'd1000, 63'd0}, 1'b1, '{63'd1000, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{'{63'd1001000, 63'd1000000000}, 1'b0, none});
        rows.push_back('{'{63'd1002000, 63'd1001000000}, 1'b0, none});
        rows.push_back('{'{63'd1003000, 63'd1002000000}, 1'b0, none});
        rows.push_back('{'{63'd1500000, 63'd1500000000}, 1'b0, none});
        rows.push_back('{'{63'd1600000, 63'd3000000000}, 1'b0, none});
        rows.push_back('{'{63'd20000000, 63'd20000000000}, 1'b0, none});
        rows.push_back('{'{63'd20000100, 63'd20000100000}, 1'b0, none});
        rows.push_back('{'{63'd19999000, 63'd19999000000}, 1'b0, none});
        rows.push_back('{'{63'd0, 63'd0}, 1'b0, none});
        rows.push_back('{'{MASK63, MASK63}, 1'b0, none});
        rows.push_back('{'{MASK63, 63'd0}, 1'b0, none});
        rows.push_back('{'{63'd0, MASK63}, 1'b0, none});
        rows.push_back('{'{63'd5, 63'd5}, 1'b0, none});
        rows.push_back('{'{63'd5, 63'd5}, 1'b0, none});
        rows.push_back('{'{63'd30000000, 63'd2}, 1'b0, none});
        rows.push_back('{'{63'd90000000, 63'd922337203685}, 1'b0, none});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], cfg_set[0][r]);
        cfg_valid <= 1'b0;
        foreach (rows[i]) begin
            rw = rows[i];
            send_beat(rw.beat, rw.fixed, rw.value);
        end
        drain();

        for (int seg = 0; seg < N_PHASES; seg++) begin
            repeat (200) @(posedge aclk);
            for (int r = 0; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], cfg_set[seg][r]);
            cfg_valid <= 1'b0;
            case (seg % 3)
                0: begin tx_idle_pct = 35; rx_idle_pct = 76; end
                1: begin tx_idle_pct = 76; rx_idle_pct = 35; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (seg == 0 && n == 10) hold_tok++;
                if (seg == 1 && n == 40) drain();
                send_beat(next_beat(), 1'b0, none);
            end
            drain();
        end

        repeat (200) @(posedge aclk);
        if (errors == 0 && time_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ----- counter_interpolated_clock.f -----
src/cic_pkg.sv
src/cic_div.sv
src/cic_dp.sv
src/cic_ctrl.sv
src/counter_interpolated_clock.sv
src/cic_checker.sv
verif/tb_counter_interpolated_clock.sv
